/* rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg: shared definitions for the outlier rejecting window mean
// Field widths, register reset value and default window size.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TOL_W       = 7;
  localparam int KEPT_W      = 4;
  localparam int WINDOW_DEF  = 10;
  localparam int PCT_DIV     = 100;

  localparam logic [TOL_W-1:0] TOL_RESET = 7'd10;

endpackage

/* rtl/owm_if.sv */
// ----------------------------------------------------------------------------
// owm_in_if / owm_out_if: valid-ready channels of the window mean
// One word moves at each rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface owm_in_if;
  logic                          valid;
  logic                          ready;
  logic [owm_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface owm_out_if;
  logic                          valid;
  logic                          ready;
  logic [owm_pkg::SAMPLE_W-1:0]  filtered_mean;
  logic [owm_pkg::KEPT_W-1:0]    kept_count;

  modport source (output valid, output filtered_mean, output kept_count, input ready);
  modport sink   (input valid, input filtered_mean, input kept_count, output ready);
endinterface

/* rtl/owm_ram.sv */
// ----------------------------------------------------------------------------
// owm_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module owm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/outlier_rejecting_window_mean.sv */
// ----------------------------------------------------------------------------
// outlier_rejecting_window_mean: moving average with outlier rejection
// Keeps a circular window of samples and returns the mean of the entries
// that lie within a tolerance band around the plain window mean.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   in_bus    in   valid / ready    sample[15:0]
//   out_bus   out  valid / ready    filtered_mean[15:0], kept_count[3:0]
//   cfg       in   cfg_we           cfg_wdata[6:0] (tolerance percent)
//
// Each word is handled by two read passes over the window RAM (one entry a
// cycle) and three divisions on the shared restoring divider (one quotient
// bit a cycle); a new word is accepted only after the previous one is
// finished. Synchronous reset clears the window through per-entry valid
// bits, so no clearing pass is needed. The input is ready only while idle;
// a finished result sits in the output register and a stalled output only
// holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module outlier_rejecting_window_mean #(
  parameter int WINDOW_SIZE = owm_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  owm_in_if.sink                    in_bus,
  owm_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [owm_pkg::TOL_W-1:0] cfg_wdata
);

  import owm_pkg::*;

  // Address, count and sum widths follow from the window size.
  localparam int AW     = $clog2(WINDOW_SIZE);
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int PROD_W = SAMPLE_W + TOL_W;
  localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DVR_W  = (CNT_W > TOL_W) ? CNT_W : TOL_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int DEV_W  = SAMPLE_W + 1;
  localparam int BAND_W = SAMPLE_W + 2;
  localparam int KX_W   = (CNT_W > KEPT_W) ? CNT_W : KEPT_W;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SUM      = 8'b0000_0010,
    ST_MEAN_DIV = 8'b0000_0100,
    ST_DEV_MUL  = 8'b0000_1000,
    ST_DEV_DIV  = 8'b0001_0000,
    ST_BAND     = 8'b0010_0000,
    ST_AVG_DIV  = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]       tol_r;
  logic [AW-1:0]          slot_r, slot_nxt;
  logic [WINDOW_SIZE-1:0] valid_r;

  // Read pass bookkeeping: issue counter and a flag for data in flight.
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic                   rd_valid_r;
  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;

  logic [SAMPLE_W-1:0]    mean_r, mean_nxt;
  logic [DEV_W-1:0]       dev_r, dev_nxt;
  logic [BAND_W-1:0]      hi_r, hi_nxt;

  // Shared restoring divider.
  logic [DIV_W-1:0]       div_quo_r, div_quo_nxt;
  logic [DVR_W-1:0]       div_rem_r, div_rem_nxt;
  logic [DVR_W-1:0]       div_dvr_r, div_dvr_nxt;
  logic [DCNT_W-1:0]      div_cnt_r, div_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]    out_mean_r, out_mean_nxt;
  logic [KEPT_W-1:0]      out_kept_r, out_kept_nxt;

  logic                   in_accept;
  logic [AW-1:0]          raddr;
  logic [SAMPLE_W-1:0]    ram_rdata;
  logic [SAMPLE_W-1:0]    entry;
  logic                   issue;
  logic                   pass_done;
  logic                   in_band;
  logic [BAND_W-1:0]      entry_plus_dev;
  logic [DVR_W:0]         rem_sh;
  logic [DVR_W:0]         rem_sub;
  logic                   fits;
  logic [DVR_W-1:0]       rem_step;
  logic [DIV_W-1:0]       quo_step;
  logic                   div_done;
  logic [PROD_W-1:0]      product;
  logic [DEV_W-1:0]       dev_q;
  logic [KX_W-1:0]        kept_x;

  assign in_accept    = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);

  assign out_bus.valid         = out_valid_r;
  assign out_bus.filtered_mean = out_mean_r;
  assign out_bus.kept_count    = out_kept_r;

  // The new sample is written at the accept edge; both passes follow it.
  owm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (in_accept),
    .waddr (slot_r),
    .wdata (in_bus.sample),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // A slot never written since reset reads as zero.
  assign entry     = rd_valid_r ? ram_rdata : '0;
  assign issue     = (cnt_r < CNT_W'(WINDOW_SIZE));
  assign raddr     = cnt_r[AW-1:0];
  assign pass_done = !issue && !pend_r;

  // Band test without signed values: v >= mean - dev is v + dev >= mean.
  assign entry_plus_dev = BAND_W'(entry) + BAND_W'(dev_r);
  assign in_band = (entry_plus_dev >= BAND_W'(mean_r)) && (BAND_W'(entry) <= hi_r);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {div_rem_r, div_quo_r[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_dvr_r};
  assign fits     = (rem_sh >= {1'b0, div_dvr_r});
  assign rem_step = fits ? rem_sub[DVR_W-1:0] : rem_sh[DVR_W-1:0];
  assign quo_step = {div_quo_r[DIV_W-2:0], fits};
  assign div_done = (div_cnt_r == '0);

  assign product = PROD_W'(mean_r) * PROD_W'(tol_r);
  assign dev_q   = div_quo_r[DEV_W-1:0];
  assign kept_x  = KX_W'(kept_r);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    kept_nxt      = kept_r;
    mean_nxt      = mean_r;
    dev_nxt       = dev_r;
    hi_nxt        = hi_r;
    div_quo_nxt   = div_quo_r;
    div_rem_nxt   = div_rem_r;
    div_dvr_nxt   = div_dvr_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_mean_nxt  = out_mean_r;
    out_kept_nxt  = out_kept_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          slot_nxt  = (slot_r == AW'(WINDOW_SIZE - 1)) ? '0 : slot_r + 1'b1;
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end

      ST_SUM: begin
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + SUM_W'(entry);
        end
        if (pass_done) begin
          div_quo_nxt = DIV_W'(acc_r);
          div_rem_nxt = '0;
          div_dvr_nxt = DVR_W'(WINDOW_SIZE);
          div_cnt_nxt = DCNT_W'(DIV_W);
          state_nxt   = ST_MEAN_DIV;
        end
      end

      ST_MEAN_DIV: begin
        if (div_done) begin
          mean_nxt  = div_quo_r[SAMPLE_W-1:0];
          state_nxt = ST_DEV_MUL;
        end else begin
          div_quo_nxt = quo_step;
          div_rem_nxt = rem_step;
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end

      ST_DEV_MUL: begin
        div_quo_nxt = DIV_W'(product);
        div_rem_nxt = '0;
        div_dvr_nxt = DVR_W'(PCT_DIV);
        div_cnt_nxt = DCNT_W'(DIV_W);
        state_nxt   = ST_DEV_DIV;
      end

      ST_DEV_DIV: begin
        if (div_done) begin
          dev_nxt   = dev_q;
          hi_nxt    = BAND_W'(mean_r) + BAND_W'(dev_q);
          cnt_nxt   = '0;
          acc_nxt   = '0;
          kept_nxt  = '0;
          state_nxt = ST_BAND;
        end else begin
          div_quo_nxt = quo_step;
          div_rem_nxt = rem_step;
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end

      ST_BAND: begin
        pend_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pend_r && in_band) begin
          acc_nxt  = acc_r + SUM_W'(entry);
          kept_nxt = kept_r + 1'b1;
        end
        if (pass_done) begin
          div_quo_nxt = DIV_W'(acc_r);
          div_rem_nxt = '0;
          div_dvr_nxt = DVR_W'(kept_r);
          div_cnt_nxt = DCNT_W'(DIV_W);
          state_nxt   = ST_AVG_DIV;
        end
      end

      ST_AVG_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end else begin
          div_quo_nxt = quo_step;
          div_rem_nxt = rem_step;
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end

      ST_EMIT: begin
        // Wait here only while the previous result is still unread.
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = (kept_r == '0) ? '0 : div_quo_r[SAMPLE_W-1:0];
          out_kept_nxt  = (kept_x > KX_W'({KEPT_W{1'b1}})) ? {KEPT_W{1'b1}}
                                                           : kept_x[KEPT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= TOL_RESET;
      slot_r      <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (in_accept) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r   <= valid_r[raddr];
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    kept_r       <= kept_nxt;
    mean_r       <= mean_nxt;
    dev_r        <= dev_nxt;
    hi_r         <= hi_nxt;
    div_quo_r    <= div_quo_nxt;
    div_rem_r    <= div_rem_nxt;
    div_dvr_r    <= div_dvr_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_mean_r   <= out_mean_nxt;
    out_kept_r   <= out_kept_nxt;
  end

endmodule
